// ----- src/dfts_pkg.sv -----
// shared types and constants of the deadline-first task scheduler
package dfts_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int DAY_BITS_DEF    = 16;
    localparam int DL_W            = 16;
    localparam int COUNT_W         = 32;

    typedef enum logic [1:0] {
        ST_QUEUED = 2'd0,
        ST_FULL   = 2'd1,
        ST_PASSED = 2'd2
    } t_status;

    // broadcast to every cell
    typedef struct packed {
        logic            insert;
        logic            day_end;
        logic [DL_W-1:0] ins_value;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic            valid;
        logic [DL_W-1:0] value;
        logic            take;
        logic            keep;
    } t_cell_link;

endpackage

// ----- src/dfts_cell.sv -----
// one cell of the sorted deadline chain
module dfts_cell
    import dfts_pkg::*;
#(
    parameter int CMP_W = DL_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [CMP_W-1:0] i_day,
    input  t_cell_link       i_left,
    input  t_cell_link       i_right,
    output t_cell_link       o_link,
    output logic             o_served
);

    logic            r_valid;
    logic [DL_W-1:0] r_value;
    logic            n_valid;
    logic [DL_W-1:0] n_value;
    logic            w_take;
    logic            w_keep;
    logic            w_last_keep;

    // chain is descending, so take and keep are both monotonic along it
    assign w_take      = !r_valid || (r_value < i_ctl.ins_value);
    assign w_keep      = r_valid && (CMP_W'(r_value) >= i_day);
    assign w_last_keep = w_keep && !i_right.keep;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.insert && w_take) begin
            if (i_left.take) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else begin
                n_valid = 1'b1;
                n_value = i_ctl.ins_value;
            end
        end else if (i_ctl.day_end) begin
            n_valid = w_keep && !w_last_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.value = r_value;
    assign o_link.take  = w_take;
    assign o_link.keep  = w_keep;
    assign o_served     = i_ctl.day_end && w_last_keep;

endmodule

// ----- src/deadline_first_task_scheduler.sv -----
// top level of the earliest-deadline-first unit task scheduler
//
// Earliest-deadline-first scheduler for unit-length tasks, one task per day.
// Pending deadlines live in a chain of STORE_DEPTH cells kept sorted in
// descending order, with occupied cells packed from cell 0. An arrival item
// (cmd 0) is refused with status 2 when its deadline is before the current
// day, else with status 1 when the last cell is occupied, else every cell
// whose deadline is smaller (or which is empty) shifts one place along the
// chain and the first of them takes the new deadline. A day-end item (cmd 1)
// lets every cell compare its deadline to the current day at once: expired
// cells and the smallest live one (the last live cell of the chain) empty
// themselves, the latter being served; then the day counter and, if one
// was served, the served counter advance, both saturating. Every item is
// handled in the cycle it is accepted, one item per clock, and its single
// result item appears from the output register on the next cycle; the input
// stalls only while that register holds a result the output side stalls.
// The cell compares and the one-hot select of the served deadline set the
// clock period. There is no clearing pass: reset empties the chain at once.
module deadline_first_task_scheduler
    import dfts_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int DAY_BITS    = DAY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [DL_W-1:0]    i_deadline,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_served,
    output logic [DL_W-1:0]    o_served_deadline,
    output logic [COUNT_W-1:0] o_served_total,
    output logic [DL_W-1:0]    o_current_day,
    output logic [1:0]         o_arrival_status
);

    // compare width covers both the deadline and the day counter
    localparam int CMP_W = (DAY_BITS > DL_W) ? DAY_BITS : DL_W;

    localparam t_cell_link LINK_EDGE = '{valid: 1'b0, value: '0, take: 1'b0, keep: 1'b0};

    // counters
    logic [DAY_BITS-1:0] r_day;
    logic [DAY_BITS-1:0] n_day;
    logic [COUNT_W-1:0]  r_total;
    logic [COUNT_W-1:0]  n_total;

    // result register
    logic                r_out_valid;
    logic                r_served;
    logic [DL_W-1:0]     r_served_deadline;
    logic [COUNT_W-1:0]  r_served_total;
    logic [DL_W-1:0]     r_current_day;
    t_status             r_status;

    logic                w_acc;
    t_status             w_status;
    logic [CMP_W-1:0]    w_day_ext;
    logic [CMP_W-1:0]    w_next_day_ext;
    t_cell_ctl           w_ctl;
    t_cell_link          w_link [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] w_served_vec;
    logic [STORE_DEPTH-1:0] w_valid_vec;
    logic                w_any_served;
    logic [DL_W-1:0]     w_srv_value;

    // a new item enters unless a finished result is held by the output side
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;

    assign w_day_ext = CMP_W'(r_day);

    // passed deadline is checked before the full store
    always_comb begin
        if (CMP_W'(i_deadline) < w_day_ext) begin
            w_status = ST_PASSED;
        end else if (w_link[STORE_DEPTH-1].valid) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_QUEUED;
        end
    end

    assign w_ctl.insert    = w_acc && !i_cmd && (w_status == ST_QUEUED);
    assign w_ctl.day_end   = w_acc && i_cmd;
    assign w_ctl.ins_value = i_deadline;

    // chain of cells, cell 0 holds the largest deadline
    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (g == 0) begin : g_first
            assign w_left = LINK_EDGE;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == STORE_DEPTH - 1) begin : g_last
            assign w_right = LINK_EDGE;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        dfts_cell #(
            .CMP_W (CMP_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_day    (w_day_ext),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_link   (w_link[g]),
            .o_served (w_served_vec[g])
        );

        assign w_valid_vec[g] = w_link[g].valid;
    end

    // at most one cell serves, so an or of the gated values selects it
    always_comb begin
        w_srv_value = '0;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (w_served_vec[k]) begin
                w_srv_value = w_srv_value | w_link[k].value;
            end
        end
    end

    assign w_any_served = |w_served_vec;

    // saturating counters, updated on day end only
    always_comb begin
        n_day   = r_day;
        n_total = r_total;
        if (w_ctl.day_end) begin
            if (r_day != '1) begin
                n_day = r_day + 1'b1;
            end
            if (w_any_served && (r_total != '1)) begin
                n_total = r_total + 1'b1;
            end
        end
    end

    assign w_next_day_ext = CMP_W'(n_day);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= DAY_BITS'(1);
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_day   <= n_day;
            r_total <= n_total;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only when an item is accepted
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_served          <= w_ctl.day_end && w_any_served;
            r_served_deadline <= w_ctl.day_end ? w_srv_value : '0;
            r_served_total    <= n_total;
            r_current_day     <= w_next_day_ext[DL_W-1:0];
            r_status          <= i_cmd ? ST_QUEUED : w_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_served          = r_served;
    assign o_served_deadline = r_served_deadline;
    assign o_served_total    = r_served_total;
    assign o_current_day     = r_current_day;
    assign o_arrival_status  = r_status;

`ifndef SYNTHESIS
    // occupied cells always form a run starting at cell 0
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((w_valid_vec + 1'b1) & w_valid_vec) == '0))
        else $error("occupied cells not packed at chain head");

    // a day end never serves from more than one cell
    a_one_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_served_vec))
        else $error("more than one cell served");

    // a queued arrival adds exactly one occupied cell
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_ctl.insert) |=>
            ($countones(w_valid_vec) == $past($countones(w_valid_vec)) + 1))
        else $error("arrival did not add exactly one entry");

    // the day counter never wraps to zero
    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day != '0))
        else $error("day counter wrapped");
`endif

endmodule
